### rtl/core/differential_drive_steering_assert.svh
// Assertion macros for the differential drive steering block.
`ifndef DIFFERENTIAL_DRIVE_STEERING_ASSERT_SVH
`define DIFFERENTIAL_DRIVE_STEERING_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property out of reset on the block clock.
`define DDS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("steering check failed");
// Check a property at every edge, reset included.
`define DDS_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("steering reset check failed");
`else
`define DDS_ASSERT(label, prop)
`define DDS_ASSERT_RST(label, prop)
`endif
`endif

### rtl/core/dds_pkg.sv
// Types, constants and the arctangent table of the steering block.
package dds_pkg;

  // Fixed widths of the datapath
  localparam int SQ_STEPS   = 17;  // root bits of a 34 bit radicand
  localparam int XW         = 36;  // CORDIC x and y
  localparam int RADW       = 34;  // dx^2 + dy^2
  localparam int RW         = 35;  // root accumulator
  localparam int DIV_BITS   = 16;
  localparam int TNUM_W     = 40;
  localparam int TDEN_W     = 41;
  localparam int TW         = TDEN_W + DIV_BITS;
  localparam int PNUM_W     = 30;
  localparam int PDEN_W     = 16;
  localparam int PW         = PDEN_W + DIV_BITS;

  localparam logic [25:0] PI_Q24    = 26'd52707179;
  localparam logic [14:0] TURN_CAP  = 15'h7FFF;
  localparam logic [15:0] TENTH_Q14 = 16'd1638;
  localparam logic [16:0] PEN_CAP   = 17'h10000;

  typedef enum logic [2:0] {
    CFG_TURN_GAIN        = 3'd0,
    CFG_TURN_SOFTNESS    = 3'd1,
    CFG_SPIN_THRESHOLD   = 3'd2,
    CFG_SPEED_OFFSET     = 3'd3,
    CFG_DISTANCE_PENALTY = 3'd4,
    CFG_PWM_PERIOD       = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic               navigate;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] heading;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic [15:0]        range_left;
    logic [15:0]        range_center;
    logic [15:0]        range_right;
  } in_t;

  typedef struct packed {
    logic [15:0]        compare_left;
    logic [15:0]        compare_right;
    logic               reverse_left;
    logic               reverse_right;
    logic signed [15:0] heading_error;
    logic [15:0]        nearest_distance;
  } out_t;

  // Fields riding along the bearing and root pipeline
  typedef struct packed {
    logic               navigate;
    logic signed [15:0] heading;
    logic [15:0]        range_left;
    logic [15:0]        range_center;
    logic [15:0]        range_right;
  } fsb_t;

  // Fields riding along the divider pipeline
  typedef struct packed {
    logic               navigate;
    logic signed [15:0] heading_error;
    logic [16:0]        err_mag;
    logic [15:0]        nearest_distance;
  } msb_t;

  // Divider results
  typedef struct packed {
    logic [DIV_BITS-1:0] tquo;
    logic                tsat;
    logic [DIV_BITS-1:0] pquo;
    logic                psat;
  } div_res_t;

  // atan(2^-i) as a fraction of a full turn, 32 bit
  function automatic logic [31:0] atan_tab(input int idx);
    logic [31:0] v;
    case (idx)
      0:  v = 32'd536870912;
      1:  v = 32'd316933406;
      2:  v = 32'd167458907;
      3:  v = 32'd85004756;
      4:  v = 32'd42667331;
      5:  v = 32'd21354465;
      6:  v = 32'd10679838;
      7:  v = 32'd5340245;
      8:  v = 32'd2670163;
      9:  v = 32'd1335087;
      10: v = 32'd667544;
      11: v = 32'd333772;
      12: v = 32'd166886;
      13: v = 32'd83443;
      14: v = 32'd41722;
      15: v = 32'd20861;
      16: v = 32'd10430;
      17: v = 32'd5215;
      18: v = 32'd2608;
      19: v = 32'd1304;
      20: v = 32'd652;
      21: v = 32'd326;
      22: v = 32'd163;
      23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/dds_front.sv
// Bearing CORDIC and distance square root, one step of each per stage.
module dds_front #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 14
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic signed [16:0] dx_i,
  input  logic signed [16:0] dy_i,
  input  dds_pkg::fsb_t      side_i,
  output logic               valid_o,
  output logic [15:0]        bearing_o,
  output logic [16:0]        root_o,
  output dds_pkg::fsb_t      side_o
);

  localparam int NS = (CORDIC_STEPS > dds_pkg::SQ_STEPS) ? CORDIC_STEPS : dds_pkg::SQ_STEPS;
  localparam int XW = dds_pkg::XW;
  localparam int RADW = dds_pkg::RADW;
  localparam int RW = dds_pkg::RW;
  localparam int TSHIFT = 32 - ANGLE_BITS;

  logic signed [XW-1:0]   x_q    [NS+1];
  logic signed [XW-1:0]   y_q    [NS+1];
  logic [ANGLE_BITS-1:0]  z_q    [NS+1];
  logic [RADW-1:0]        rad_q  [NS+1];
  logic [RW-1:0]          root_q [NS+1];
  logic                   zero_q [NS+1];
  logic                   vld_q  [NS+1];
  dds_pkg::fsb_t          side_q [NS+1];

  logic signed [XW-1:0]   x_sc, y_sc, x_init, y_init;
  logic [ANGLE_BITS-1:0]  z_init;
  logic signed [33:0]     sqx, sqy;
  logic [RADW-1:0]        rad_init;

  // Scale, fold into the right half plane and square
  always_comb begin
    x_sc     = {{(XW-33){dx_i[16]}}, dx_i, 16'h0000};
    y_sc     = {{(XW-33){dy_i[16]}}, dy_i, 16'h0000};
    x_init   = dx_i[16] ? -x_sc : x_sc;
    y_init   = dx_i[16] ? -y_sc : y_sc;
    z_init   = dx_i[16] ? {1'b1, {(ANGLE_BITS-1){1'b0}}} : '0;
    sqx      = dx_i * dx_i;
    sqy      = dy_i * dy_i;
    rad_init = $unsigned(sqx) + $unsigned(sqy);
  end

  // Entry stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q[0]    <= x_init;
      y_q[0]    <= y_init;
      z_q[0]    <= z_init;
      rad_q[0]  <= rad_init;
      root_q[0] <= '0;
      zero_q[0] <= (dx_i == 17'sd0) && (dy_i == 17'sd0);
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic signed [XW-1:0]  x_n, y_n, xs, ys;
    logic [ANGLE_BITS-1:0] z_n;
    logic [RADW-1:0]       rad_n;
    logic [RW-1:0]         root_n, cand;

    // Vectoring step: rotate toward the x axis
    if (k < CORDIC_STEPS) begin : g_cor
      localparam logic [32:0] TSUM = {1'b0, dds_pkg::atan_tab(k)} + (33'd1 << (TSHIFT - 1));
      localparam logic [ANGLE_BITS-1:0] TSTEP = ANGLE_BITS'(TSUM >> TSHIFT);
      always_comb begin
        xs = x_q[k] >>> k;
        ys = y_q[k] >>> k;
        if (!y_q[k][XW-1]) begin
          x_n = x_q[k] + ys;
          y_n = y_q[k] - xs;
          z_n = z_q[k] + TSTEP;
        end else begin
          x_n = x_q[k] - ys;
          y_n = y_q[k] + xs;
          z_n = z_q[k] - TSTEP;
        end
      end
    end else begin : g_cor_pass
      assign xs  = '0;
      assign ys  = '0;
      assign x_n = x_q[k];
      assign y_n = y_q[k];
      assign z_n = z_q[k];
    end

    // One root bit: try the next odd square
    if (k < dds_pkg::SQ_STEPS) begin : g_sq
      localparam logic [RW-1:0] SQBIT = RW'(1) << (32 - 2 * k);
      always_comb begin
        cand = root_q[k] + SQBIT;
        if (RW'(rad_q[k]) >= cand) begin
          rad_n  = RADW'(RW'(rad_q[k]) - cand);
          root_n = (root_q[k] >> 1) + SQBIT;
        end else begin
          rad_n  = rad_q[k];
          root_n = root_q[k] >> 1;
        end
      end
    end else begin : g_sq_pass
      assign cand   = '0;
      assign rad_n  = rad_q[k];
      assign root_n = root_q[k];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        x_q[k+1]    <= x_n;
        y_q[k+1]    <= y_n;
        z_q[k+1]    <= z_n;
        rad_q[k+1]  <= rad_n;
        root_q[k+1] <= root_n;
        zero_q[k+1] <= zero_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  // Bring the accumulated angle to 16 bits, rounding it when it is wider
  logic [15:0] z16;
  if (ANGLE_BITS > 16) begin : g_round
    localparam int DOWN = ANGLE_BITS - 16;
    logic [ANGLE_BITS-1:0] zr;
    assign zr  = z_q[NS] + (ANGLE_BITS'(1) << (DOWN - 1));
    assign z16 = zr[ANGLE_BITS-1:DOWN];
  end else if (ANGLE_BITS == 16) begin : g_exact
    assign z16 = z_q[NS];
  end else begin : g_widen
    assign z16 = {z_q[NS], {(16-ANGLE_BITS){1'b0}}};
  end

  assign valid_o   = vld_q[NS];
  assign bearing_o = zero_q[NS] ? 16'h0000 : z16;
  assign root_o    = root_q[NS][16:0];
  assign side_o    = side_q[NS];

endmodule

### rtl/core/dds_div.sv
// Two restoring dividers, turn ratio and distance penalty, one quotient bit per stage.
module dds_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [dds_pkg::TNUM_W-1:0]    tnum_i,
  input  logic [dds_pkg::TDEN_W-1:0]    tden_i,
  input  logic [dds_pkg::PNUM_W-1:0]    pnum_i,
  input  logic [dds_pkg::PDEN_W-1:0]    pden_i,
  input  dds_pkg::msb_t                 side_i,
  output logic                          valid_o,
  output dds_pkg::div_res_t             res_o,
  output dds_pkg::msb_t                 side_o
);

  localparam int NB = dds_pkg::DIV_BITS;
  localparam int TW = dds_pkg::TW;
  localparam int PW = dds_pkg::PW;

  logic [TW-1:0]                 trem_q [NB+1];
  logic [dds_pkg::TDEN_W-1:0]    tden_q [NB+1];
  logic [NB-1:0]                 tquo_q [NB+1];
  logic                          tsat_q [NB+1];
  logic [PW-1:0]                 prem_q [NB+1];
  logic [dds_pkg::PDEN_W-1:0]    pden_q [NB+1];
  logic [NB-1:0]                 pquo_q [NB+1];
  logic                          psat_q [NB+1];
  logic                          vld_q  [NB+1];
  dds_pkg::msb_t                 side_q [NB+1];

  logic tsat_in, psat_in;

  // Quotient would not fit: flag saturation, a zero numerator gives zero
  assign tsat_in = (tnum_i != '0) && (TW'(tnum_i) >= (TW'(tden_i) << NB));
  assign psat_in = (pnum_i != '0) && (PW'(pnum_i) >= (PW'(pden_i) << NB));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      trem_q[0] <= TW'(tnum_i);
      tden_q[0] <= tden_i;
      tquo_q[0] <= '0;
      tsat_q[0] <= tsat_in;
      prem_q[0] <= PW'(pnum_i);
      pden_q[0] <= pden_i;
      pquo_q[0] <= '0;
      psat_q[0] <= psat_in;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int B = NB - 1 - k;
    logic [TW-1:0] tsh, trem_n;
    logic [PW-1:0] psh, prem_n;
    logic [NB-1:0] tquo_n, pquo_n;

    // Subtract the shifted divisor where it fits; a zero divisor sets no bit
    always_comb begin
      tsh    = TW'(tden_q[k]) << B;
      psh    = PW'(pden_q[k]) << B;
      tquo_n = tquo_q[k];
      pquo_n = pquo_q[k];
      trem_n = trem_q[k];
      prem_n = prem_q[k];
      if ((tsh != '0) && (trem_q[k] >= tsh)) begin
        trem_n    = trem_q[k] - tsh;
        tquo_n[B] = 1'b1;
      end
      if ((psh != '0) && (prem_q[k] >= psh)) begin
        prem_n    = prem_q[k] - psh;
        pquo_n[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        trem_q[k+1] <= trem_n;
        tden_q[k+1] <= tden_q[k];
        tquo_q[k+1] <= tquo_n;
        tsat_q[k+1] <= tsat_q[k];
        prem_q[k+1] <= prem_n;
        pden_q[k+1] <= pden_q[k];
        pquo_q[k+1] <= pquo_n;
        psat_q[k+1] <= psat_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o    = vld_q[NB];
  assign res_o.tquo = tquo_q[NB];
  assign res_o.tsat = tsat_q[NB];
  assign res_o.pquo = pquo_q[NB];
  assign res_o.psat = psat_q[NB];
  assign side_o     = side_q[NB];

endmodule

### rtl/core/dds_pwm.sv
// Duty to direction bit and PWM compare value, two register stages.
module dds_pwm (
  input  logic               clk_i,
  input  logic               adv_i,
  input  logic signed [15:0] duty_i,
  input  logic [15:0]        period_i,
  output logic [15:0]        cmp_o,
  output logic               rev_o
);

  logic signed [16:0] c;
  logic               rev, cpos;
  logic [30:0]        prod;
  logic [30:0]        prod_q;
  logic               rev_q, cpos_q;
  logic [16:0]        quo;
  logic [15:0]        cmp_d;
  logic [15:0]        cmp_q;
  logic               rev2_q;

  // Pick direction and fold the duty into a positive magnitude
  always_comb begin
    if (!duty_i[15] && (duty_i != 16'sd0)) begin
      rev = 1'b0;
      c   = {duty_i[15], duty_i};
    end else begin
      rev = 1'b1;
      c   = 17'sd16384 + {duty_i[15], duty_i};
    end
    cpos = !c[16] && (c != 17'sd0);
    prod = 31'(c[14:0]) * 31'(period_i);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod;
      rev_q  <= rev;
      cpos_q <= cpos;
    end
  end

  // Scale by the period and clamp to it
  always_comb begin
    quo = prod_q[30:14];
    if (!cpos_q) begin
      cmp_d = 16'h0000;
    end else if (quo > {1'b0, period_i}) begin
      cmp_d = period_i;
    end else begin
      cmp_d = quo[15:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cmp_q  <= cmp_d;
      rev2_q <= rev_q;
    end
  end

  assign cmp_o = cmp_q;
  assign rev_o = rev2_q;

endmodule

### rtl/core/differential_drive_steering.sv
// Differential drive steering: bearing, distance, turn and speed terms to PWM compares.
// Throughput: one request per cycle; the whole pipeline holds while a result waits.
// Depth is set by the one-step-per-stage CORDIC and root, and the 16 bit quotient dividers.
// Reset (async, active low) empties all valid bits and loads the register defaults.
`include "differential_drive_steering_assert.svh"
module differential_drive_steering #(
  parameter int ANGLE_BITS   = 16,
  parameter int CORDIC_STEPS = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dds_pkg::in_t  in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output dds_pkg::out_t out_req_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_idx_i,
  input  logic [15:0]   cfg_data_i
);

  logic adv;

  // Configuration registers
  logic [15:0]        gain_q, soft_q, pen_gain_q, pwm_period_q;
  logic [14:0]        spin_q;
  logic signed [15:0] offset_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= 16'd256;
      soft_q       <= 16'd256;
      spin_q       <= 15'd8192;
      offset_q     <= 16'sd8192;
      pen_gain_q   <= 16'd0;
      pwm_period_q <= 16'd1000;
    end else if (cfg_valid_i) begin
      unique case (dds_pkg::cfg_idx_e'(cfg_idx_i))
        dds_pkg::CFG_TURN_GAIN:        gain_q       <= cfg_data_i;
        dds_pkg::CFG_TURN_SOFTNESS:    soft_q       <= cfg_data_i;
        dds_pkg::CFG_SPIN_THRESHOLD:   spin_q       <= cfg_data_i[14:0];
        dds_pkg::CFG_SPEED_OFFSET:     offset_q     <= cfg_data_i;
        dds_pkg::CFG_DISTANCE_PENALTY: pen_gain_q   <= cfg_data_i;
        dds_pkg::CFG_PWM_PERIOD:       pwm_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance everything unless a finished result is held
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // Capture the request
  logic         v0_q;
  dds_pkg::in_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q <= in_req_i;
    end
  end

  logic signed [16:0] dx, dy;
  dds_pkg::fsb_t      fside_in, fside_out;
  logic               fvalid;
  logic [15:0]        bearing;
  logic [16:0]        root;

  assign dx = {in_q.target_x[15], in_q.target_x} - {in_q.pos_x[15], in_q.pos_x};
  assign dy = {in_q.target_y[15], in_q.target_y} - {in_q.pos_y[15], in_q.pos_y};
  assign fside_in = '{navigate: in_q.navigate, heading: in_q.heading,
                      range_left: in_q.range_left, range_center: in_q.range_center,
                      range_right: in_q.range_right};

  dds_front #(
    .ANGLE_BITS  (ANGLE_BITS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (v0_q),
    .dx_i     (dx),
    .dy_i     (dy),
    .side_i   (fside_in),
    .valid_o  (fvalid),
    .bearing_o(bearing),
    .root_o   (root),
    .side_o   (fside_out)
  );

  // Heading error, its magnitude and the nearest distance
  logic [15:0]   err;
  logic [16:0]   err17, mag, dmin17;
  dds_pkg::msb_t m1_d, m1_q, m2_q, m3_q;
  logic          m1_v_q, m2_v_q, m3_v_q;

  always_comb begin
    err    = bearing - fside_out.heading;
    err17  = {err[15], err};
    mag    = err[15] ? 17'(-err17) : err17;
    dmin17 = root;
    if ({1'b0, fside_out.range_left} < dmin17) begin
      dmin17 = {1'b0, fside_out.range_left};
    end
    if ({1'b0, fside_out.range_center} < dmin17) begin
      dmin17 = {1'b0, fside_out.range_center};
    end
    if ({1'b0, fside_out.range_right} < dmin17) begin
      dmin17 = {1'b0, fside_out.range_right};
    end
    m1_d.navigate         = fside_out.navigate;
    m1_d.heading_error    = err;
    m1_d.err_mag          = mag;
    m1_d.nearest_distance = dmin17[15:0];
  end

  // Error in radians, Q16
  logic [42:0] eprod;
  logic [17:0] erad_q;

  assign eprod = 43'(m1_q.err_mag) * 43'(dds_pkg::PI_Q24) + (43'd1 << 22);

  // Divider operands
  logic [24:0]                    tsum;
  logic [dds_pkg::TNUM_W-1:0]     tnum_q;
  logic [dds_pkg::TDEN_W-1:0]     tden_q;
  logic [dds_pkg::PNUM_W-1:0]     pnum_q;
  logic [dds_pkg::PDEN_W-1:0]     pden_q;

  assign tsum = 25'(erad_q) + (25'(soft_q) << 8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_v_q <= 1'b0;
      m2_v_q <= 1'b0;
      m3_v_q <= 1'b0;
    end else if (adv) begin
      m1_v_q <= fvalid;
      m2_v_q <= m1_v_q;
      m3_v_q <= m2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_q   <= m1_d;
      m2_q   <= m1_q;
      erad_q <= eprod[40:23];
      m3_q   <= m2_q;
      tnum_q <= {erad_q, 22'h000000};
      tden_q <= 41'(gain_q) * 41'(tsum);
      pnum_q <= {pen_gain_q, 14'h0000};
      pden_q <= m2_q.nearest_distance;
    end
  end

  logic               dvalid;
  dds_pkg::div_res_t  dres;
  dds_pkg::msb_t      dside;

  dds_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .valid_i(m3_v_q),
    .tnum_i (tnum_q),
    .tden_i (tden_q),
    .pnum_i (pnum_q),
    .pden_i (pden_q),
    .side_i (m3_q),
    .valid_o(dvalid),
    .res_o  (dres),
    .side_o (dside)
  );

  // Saturate a wide duty into Q2.14 range
  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Turn term, forward speed and the two duties
  logic [14:0]        ratio, turn;
  logic [15:0]        tplus;
  logic [16:0]        pen;
  logic               spin;
  logic signed [17:0] speed;
  logic signed [18:0] sp19, tr19;
  logic signed [15:0] dl_d, dr_d;

  always_comb begin
    if (dres.tsat || dres.tquo[15]) begin
      ratio = dds_pkg::TURN_CAP;
    end else begin
      ratio = dres.tquo[14:0];
    end
    tplus = {1'b0, ratio} + dds_pkg::TENTH_Q14;
    turn  = (tplus > {1'b0, dds_pkg::TURN_CAP}) ? dds_pkg::TURN_CAP : tplus[14:0];
    pen   = dres.psat ? dds_pkg::PEN_CAP : {1'b0, dres.pquo};
    spin  = dside.err_mag > {2'b00, spin_q};
    speed = spin ? 18'sd0 : ({{2{offset_q[15]}}, offset_q} - $signed({1'b0, pen}));
    sp19  = {speed[17], speed};
    tr19  = $signed({4'b0000, turn});
    if (dside.heading_error[15]) begin
      dl_d = sat16(sp19 + tr19);
      dr_d = sat16(sp19 - tr19);
    end else begin
      dl_d = sat16(sp19 - tr19);
      dr_d = sat16(sp19 + tr19);
    end
  end

  logic signed [15:0] dl_q, dr_q;
  dds_pkg::msb_t      b1_q, p1_q, o_q;
  logic               b1_v_q, p1_v_q, o_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else if (adv) begin
      b1_v_q <= dvalid;
      p1_v_q <= b1_v_q;
      o_v_q  <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q <= dl_d;
      dr_q <= dr_d;
      b1_q <= dside;
      p1_q <= b1_q;
      o_q  <= p1_q;
    end
  end

  logic [15:0] cmp_l, cmp_r;
  logic        rev_l, rev_r;

  dds_pwm u_pwm_left (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .duty_i  (dl_q),
    .period_i(pwm_period_q),
    .cmp_o   (cmp_l),
    .rev_o   (rev_l)
  );

  dds_pwm u_pwm_right (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .duty_i  (dr_q),
    .period_i(pwm_period_q),
    .cmp_o   (cmp_r),
    .rev_o   (rev_r)
  );

  // Drop every output field to zero in idle mode
  assign out_valid_o                = o_v_q;
  assign out_req_o.compare_left     = o_q.navigate ? cmp_l : 16'h0000;
  assign out_req_o.compare_right    = o_q.navigate ? cmp_r : 16'h0000;
  assign out_req_o.reverse_left     = o_q.navigate & rev_l;
  assign out_req_o.reverse_right    = o_q.navigate & rev_r;
  assign out_req_o.heading_error    = o_q.navigate ? o_q.heading_error : 16'sh0000;
  assign out_req_o.nearest_distance = o_q.navigate ? o_q.nearest_distance : 16'h0000;

  // Spin detection at the output, for checking
  logic spin_hit;
  assign spin_hit = out_valid_o && o_q.navigate && (o_q.err_mag > {2'b00, spin_q});

  `DDS_ASSERT(a_cmp_left_in_period, out_valid_o |-> (out_req_o.compare_left <= pwm_period_q))
  `DDS_ASSERT(a_cmp_right_in_period, out_valid_o |-> (out_req_o.compare_right <= pwm_period_q))
  `DDS_ASSERT(a_spin_opposite_dirs, spin_hit |-> (out_req_o.reverse_left != out_req_o.reverse_right))
  `DDS_ASSERT_RST(a_reset_empties, !rst_ni |=> !out_valid_o)

endmodule
